### hw/rtl/ucre_pkg.sv
package ucre_pkg;

  // Frame layout and register defaults.
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam logic [7:0] FRAME_MARK = 8'hF5;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // Configuration register map, as word indexes.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_RX    = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // Result set handed from the exchange logic to the output stage.
  typedef struct packed {
    logic        load;
    logic        frame;
    kind_t       kind;
    logic [31:0] word;
    logic [31:0] cmd;
    logic [7:0]  chk;
  } resp_set_t;

  // Byte of the outgoing frame at a given position.
  function automatic logic [7:0] frame_byte(input logic [31:0] cmd,
                                            input logic [7:0] chk,
                                            input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = FRAME_MARK;
      3'd1: b = cmd[31:24];
      3'd2: b = cmd[23:16];
      3'd3: b = cmd[15:8];
      3'd4: b = cmd[7:0];
      3'd5: b = 8'h00;
      3'd6: b = chk;
      3'd7: b = FRAME_MARK;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/ucre_cfg.sv
module ucre_cfg
  import ucre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output logic [15:0]           timeout_ticks
);

  logic [15:0] timeout_r;
  logic [15:0] timeout_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register write decode.
  always_comb begin
    timeout_nxt = timeout_r;
    if (wr_en && (cfg_paddr[2] == REG_TIMEOUT)) begin
      timeout_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // Read back; addresses beyond the map read as zero.
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == REG_TIMEOUT) begin
      cfg_prdata = {16'd0, timeout_r};
    end
  end

  assign timeout_ticks = timeout_r;

endmodule

### hw/rtl/ucre_core.sv
module ucre_core
  import ucre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [1:0]  action,
  input  logic [31:0] command_word,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] timeout_ticks,
  output resp_set_t   resp
);

  logic [7:0]  win_r [FRAME_LEN];
  logic [7:0]  win_nxt [FRAME_LEN];
  logic [7:0]  win_sh [FRAME_LEN];
  logic        busy_r, busy_nxt;
  logic [15:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  rx_xor;
  logic [7:0]  cmd_xor;
  logic        frame_ok;

  // Window after shifting in the received byte, oldest byte at position 0.
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_sh[i] = win_r[i+1];
    end
    win_sh[FRAME_LEN-1] = rx_byte;
  end

  // Checksums of the shifted window and of the outgoing frame.
  assign rx_xor  = win_sh[1] ^ win_sh[2] ^ win_sh[3] ^ win_sh[4] ^ win_sh[5];
  assign cmd_xor = command_word[31:24] ^ command_word[23:16] ^
                   command_word[15:8] ^ command_word[7:0];

  assign frame_ok = (win_sh[0] == FRAME_MARK) && (win_sh[FRAME_LEN-1] == FRAME_MARK) &&
                    (win_sh[6] == rx_xor) && (win_sh[1] == opcode_r);

  assign elapsed_inc = (elapsed_r == TICKS_MAX) ? elapsed_r : elapsed_r + 16'd1;

  // Per-item state update and result selection.
  always_comb begin
    win_nxt     = win_r;
    busy_nxt    = busy_r;
    elapsed_nxt = elapsed_r;
    opcode_nxt  = opcode_r;
    resp.load   = 1'b0;
    resp.frame  = 1'b0;
    resp.kind   = KIND_TX;
    resp.word   = 32'd0;
    resp.cmd    = command_word;
    resp.chk    = cmd_xor;
    if (in_fire) begin
      unique case (action_t'(action))
        ACT_START: begin
          if (!busy_r) begin
            busy_nxt    = 1'b1;
            elapsed_nxt = 16'd0;
            opcode_nxt  = command_word[31:24];
            resp.load   = 1'b1;
            resp.frame  = 1'b1;
          end
        end
        ACT_RX: begin
          if (busy_r) begin
            win_nxt = win_sh;
            if (frame_ok) begin
              for (int i = 0; i < FRAME_LEN; i++) begin
                win_nxt[i] = 8'h00;
              end
              busy_nxt  = 1'b0;
              resp.load = 1'b1;
              resp.kind = KIND_OK;
              resp.word = {win_sh[1], win_sh[2], win_sh[3], win_sh[4]};
            end
          end
        end
        ACT_TICK: begin
          if (busy_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_ticks) begin
              for (int i = 0; i < FRAME_LEN; i++) begin
                win_nxt[i] = 8'h00;
              end
              busy_nxt  = 1'b0;
              resp.load = 1'b1;
              resp.kind = KIND_FAIL;
            end
          end
        end
        default: begin
          // Unused action code: nothing happens.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_r[i] <= 8'h00;
      end
      busy_r    <= 1'b0;
      elapsed_r <= 16'd0;
      opcode_r  <= 8'h00;
    end else begin
      win_r     <= win_nxt;
      busy_r    <= busy_nxt;
      elapsed_r <= elapsed_nxt;
      opcode_r  <= opcode_nxt;
    end
  end

endmodule

### hw/rtl/ucre_emit.sv
module ucre_emit
  import ucre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  resp_set_t   resp,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] response_word,
  output logic        last,
  output logic        sensor_awake,
  output logic        can_load
);

  logic             valid_r, valid_nxt;
  logic             frame_r;
  kind_t            kind_r;
  logic [31:0]      word_r;
  logic [31:0]      cmd_r;
  logic [7:0]       chk_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last_beat;
  logic             out_fire;

  assign last_beat = !frame_r || (idx_r == IDX_W'(FRAME_LEN - 1));
  assign out_fire  = valid_r & out_tready;
  // A new result set may load once the held one leaves with this beat.
  assign can_load  = !valid_r || (last_beat && out_tready);

  // Beat counter and valid flag.
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (resp.load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (out_fire) begin
      if (last_beat) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result set payload.
  always_ff @(posedge clk) begin
    if (resp.load) begin
      frame_r <= resp.frame;
      kind_r  <= resp.kind;
      word_r  <= resp.word;
      cmd_r   <= resp.cmd;
      chk_r   <= resp.chk;
    end
  end

  // Output beat fields.
  assign out_tvalid    = valid_r;
  assign kind          = frame_r ? KIND_TX : kind_r;
  assign tx_byte       = frame_r ? frame_byte(cmd_r, chk_r, idx_r) : 8'h00;
  assign response_word = frame_r ? 32'd0 : word_r;
  assign last          = last_beat;
  assign sensor_awake  = frame_r;

endmodule

### hw/rtl/uart_command_response_engine_unit.sv
// The first result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one input beat per cycle for items with no or one result while out_tready
// is high; a start command emits eight transmit beats, one per cycle while out_tready is high.
// Reset (rst_n, synchronous, active low) idles the exchange, clears the receive
// window, tick count and opcode, and loads timeout_ticks with 1000.
module uart_command_response_engine_unit
  import ucre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: command_word [31:0], rx_byte [39:32]
  input  logic [39:0]           in_tdata,
  // in_tuser: action [1:0]
  input  logic [1:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: tx_byte [7:0], response_word [39:8], sensor_awake [40], zero [47:41]
  output logic [47:0]           out_tdata,
  // out_tuser: kind [1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic        in_fire;
  logic [15:0] timeout_ticks;
  resp_set_t   resp;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [31:0] response_word;
  logic        sensor_awake;
  logic        can_load;

  assign in_tready = can_load;
  assign in_fire   = in_tvalid & in_tready;

  ucre_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .timeout_ticks (timeout_ticks)
  );

  ucre_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .action        (in_tuser),
    .command_word  (in_tdata[31:0]),
    .rx_byte       (in_tdata[39:32]),
    .timeout_ticks (timeout_ticks),
    .resp          (resp)
  );

  ucre_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .resp          (resp),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .response_word (response_word),
    .last          (out_tlast),
    .sensor_awake  (sensor_awake),
    .can_load      (can_load)
  );

  // Pack the result beat.
  assign out_tdata = {7'd0, sensor_awake, response_word, tx_byte};
  assign out_tuser = kind;

endmodule
